// File: rtl/core/w16alu_pkg.sv
// Shared types and constants for the 16-bit CPU execute unit.
// Holds the opcode codes, the sequencer state type and the word width.
// Depends on nothing.
package w16alu_pkg;

	localparam int unsigned WORD_W = 16;

	typedef logic [4:0] opcode_t;

	// Basic opcode numbering
	localparam opcode_t OP_SET = 5'h01;
	localparam opcode_t OP_ADD = 5'h02;
	localparam opcode_t OP_SUB = 5'h03;
	localparam opcode_t OP_MUL = 5'h04;
	localparam opcode_t OP_MLI = 5'h05;
	localparam opcode_t OP_DIV = 5'h06;
	localparam opcode_t OP_DVI = 5'h07;
	localparam opcode_t OP_MOD = 5'h08;
	localparam opcode_t OP_MDI = 5'h09;
	localparam opcode_t OP_AND = 5'h0a;
	localparam opcode_t OP_BOR = 5'h0b;
	localparam opcode_t OP_XOR = 5'h0c;
	localparam opcode_t OP_SHR = 5'h0d;
	localparam opcode_t OP_ASR = 5'h0e;
	localparam opcode_t OP_SHL = 5'h0f;
	localparam opcode_t OP_IFB = 5'h10;
	localparam opcode_t OP_IFC = 5'h11;
	localparam opcode_t OP_IFE = 5'h12;
	localparam opcode_t OP_IFN = 5'h13;
	localparam opcode_t OP_IFG = 5'h14;
	localparam opcode_t OP_IFA = 5'h15;
	localparam opcode_t OP_IFL = 5'h16;
	localparam opcode_t OP_IFU = 5'h17;
	localparam opcode_t OP_ADX = 5'h1a;
	localparam opcode_t OP_SBX = 5'h1b;
	localparam opcode_t OP_STI = 5'h1e;
	localparam opcode_t OP_STD = 5'h1f;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FIN
	} state_t;

	// Extra state for the output beat is kept apart from the divider flow
	typedef enum logic {
		OUT_EMPTY,
		OUT_FULL
	} out_state_t;

endpackage

// File: rtl/core/word16_cpu_alu_execute.sv
// Top level of the 16-bit CPU basic-instruction execute unit.
// Uses w16alu_pkg for opcodes, state types and the word width.
// Holds the sequencer, the shared restoring divider and the result register.

// One instruction beat is taken at a time. It is latched, evaluated in the next cycle and its
// result beat is presented from a register in the cycle after that; the unit takes the next beat
// in the cycle after that result is taken. DIV, DVI, MOD and MDI, when not skipped and with a
// nonzero divisor, run a radix-2 restoring divider over the 32-bit dividend (destination word
// in the upper half), one quotient bit per cycle. A receiver stall holds the result beat and
// keeps the input stalled. A kept skip flag makes the following instruction skipped; skipped
// conditionals keep it set.
module word16_cpu_alu_execute (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [4:0]        opcode,
	input  logic [15:0]       dest_value,
	input  logic [15:0]       source_value,
	input  logic [15:0]       overflow_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       result_word,
	output logic              result_write,
	output logic [15:0]       overflow_out,
	output logic              overflow_write,
	output logic              skip_next,
	output logic signed [1:0] index_step,
	output logic [1:0]        cycle_cost
);

	localparam int unsigned DIV_N    = 2 * w16alu_pkg::WORD_W;
	localparam int unsigned CNT_W    = $clog2(DIV_N);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N - 1);
	localparam logic [CNT_W-1:0] CNT_MOD  = CNT_W'(w16alu_pkg::WORD_W - 1);

	w16alu_pkg::state_t     state_q, state_nx;
	w16alu_pkg::out_state_t ostate_q, ostate_nx;

	// Latched operands
	w16alu_pkg::opcode_t op_q;
	logic [15:0] b_q, a_q, ex_q;
	logic        skip_q;

	// Divider registers
	logic [31:0]      dq_q;
	logic [15:0]      rem_q, d_q, mod_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;

	// Result register
	logic [15:0]       res_q, exo_q;
	logic              wr_q, exw_q, skn_q;
	logic signed [1:0] step_q;
	logic [1:0]        cost_q;

	// Sequencer controls
	logic accept, load_out, start_div, need_div, div_op, signed_div;

	assign accept = in_valid && !in_stall;

	// Divide-family decode
	always_comb begin
		div_op     = (op_q == w16alu_pkg::OP_DIV) || (op_q == w16alu_pkg::OP_DVI) ||
		             (op_q == w16alu_pkg::OP_MOD) || (op_q == w16alu_pkg::OP_MDI);
		signed_div = (op_q == w16alu_pkg::OP_DVI) || (op_q == w16alu_pkg::OP_MDI);
		need_div   = !skip_q && div_op && (a_q != 16'h0000);
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			w16alu_pkg::ST_IDLE: if (in_valid && ostate_q == w16alu_pkg::OUT_EMPTY) begin
				state_nx = w16alu_pkg::ST_EXEC;
			end
			w16alu_pkg::ST_EXEC: begin
				state_nx = need_div ? w16alu_pkg::ST_DIV : w16alu_pkg::ST_IDLE;
			end
			w16alu_pkg::ST_DIV: if (cnt_q == CNT_LAST) begin
				state_nx = w16alu_pkg::ST_FIN;
			end
			w16alu_pkg::ST_FIN: state_nx = w16alu_pkg::ST_IDLE;
			default: state_nx = w16alu_pkg::ST_IDLE;
		endcase
	end

	// Result register occupancy
	always_comb begin
		ostate_nx = ostate_q;
		unique case (ostate_q)
			w16alu_pkg::OUT_EMPTY: if (load_out) begin
				ostate_nx = w16alu_pkg::OUT_FULL;
			end
			w16alu_pkg::OUT_FULL: if (!out_stall) begin
				ostate_nx = w16alu_pkg::OUT_EMPTY;
			end
			default: ostate_nx = w16alu_pkg::OUT_EMPTY;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall  = (state_q != w16alu_pkg::ST_IDLE) || (ostate_q != w16alu_pkg::OUT_EMPTY);
		out_valid = (ostate_q == w16alu_pkg::OUT_FULL);
		start_div = (state_q == w16alu_pkg::ST_EXEC) && need_div;
		load_out  = ((state_q == w16alu_pkg::ST_EXEC) && !need_div) ||
		            (state_q == w16alu_pkg::ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= w16alu_pkg::ST_IDLE;
			ostate_q <= w16alu_pkg::OUT_EMPTY;
		end else begin
			state_q  <= state_nx;
			ostate_q <= ostate_nx;
		end
	end

	// Operand latch
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			b_q  <= dest_value;
			a_q  <= source_value;
			ex_q <= overflow_in;
		end
	end

	// Operand magnitudes for the signed divides
	logic        b_neg, a_neg;
	logic [15:0] mag_b, mag_a;
	assign b_neg = signed_div && b_q[15];
	assign a_neg = signed_div && a_q[15];
	assign mag_b = b_neg ? (16'h0000 - b_q) : b_q;
	assign mag_a = a_neg ? (16'h0000 - a_q) : a_q;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	logic [16:0] div_t, div_sub;
	logic        div_ge;
	logic [15:0] rem_nx;
	assign div_t   = {rem_q, dq_q[31]};
	assign div_ge  = div_t >= {1'b0, d_q};
	assign div_sub = div_t - {1'b0, d_q};
	assign rem_nx  = div_ge ? div_sub[15:0] : div_t[15:0];

	always_ff @(posedge clk) begin
		if (start_div) begin
			dq_q  <= {mag_b, 16'h0000};
			rem_q <= 16'h0000;
			d_q   <= mag_a;
			cnt_q <= '0;
			neg_q <= (op_q == w16alu_pkg::OP_DVI) ? (b_neg ^ a_neg) : b_neg;
		end else if (state_q == w16alu_pkg::ST_DIV) begin
			dq_q  <= {dq_q[30:0], div_ge};
			rem_q <= rem_nx;
			cnt_q <= cnt_q + 1'b1;
			// After the destination's own bits, the partial remainder is b mod a
			if (cnt_q == CNT_MOD) begin
				mod_q <= rem_nx;
			end
		end
	end

	// Shared 17x17 multiplier for MUL and MLI
	logic signed [16:0] mul_b, mul_a;
	logic signed [33:0] mul_p;
	assign mul_b = $signed({(op_q == w16alu_pkg::OP_MLI) && b_q[15], b_q});
	assign mul_a = $signed({(op_q == w16alu_pkg::OP_MLI) && a_q[15], a_q});
	assign mul_p = mul_b * mul_a;

	// Adders
	logic [16:0]        add_s;
	logic [15:0]        sub_d;
	logic [17:0]        adx_s;
	logic signed [17:0] sbx_v;
	assign add_s = {1'b0, b_q} + {1'b0, a_q};
	assign sub_d = b_q - a_q;
	assign adx_s = {2'b00, b_q} + {2'b00, a_q} + {2'b00, ex_q};
	assign sbx_v = $signed({2'b00, b_q}) - $signed({2'b00, a_q}) + $signed({2'b00, ex_q});

	// Shifters
	logic               long_sh;
	logic [4:0]         asr_sh;
	logic [31:0]        shr_w;
	logic [47:0]        shl_w;
	logic signed [31:0] asr_r, asr_e;
	assign long_sh = |a_q[15:5];
	assign asr_sh  = (a_q >= 16'd31) ? 5'd31 : a_q[4:0];
	assign shr_w   = {b_q, 16'h0000} >> a_q[4:0];
	assign shl_w   = {32'h0, b_q} << a_q[4:0];
	assign asr_r   = $signed({{16{b_q[15]}}, b_q}) >>> asr_sh;
	assign asr_e   = $signed({b_q, 16'h0000}) >>> asr_sh;

	// Divider results with sign fix
	logic [15:0] q_hi, q_lo, m_s;
	assign q_hi = neg_q ? (16'h0000 - dq_q[31:16]) : dq_q[31:16];
	assign q_lo = neg_q ? (16'h0000 - dq_q[15:0]) : dq_q[15:0];
	assign m_s  = neg_q ? (16'h0000 - mod_q) : mod_q;

	// Result selection
	logic [15:0]       res_c, exo_c;
	logic              wr_c, exw_c, skip_c, pass, cond, a_zero;
	logic signed [1:0] step_c;
	logic [1:0]        cost_c;

	always_comb begin
		res_c  = b_q;
		exo_c  = ex_q;
		wr_c   = 1'b0;
		exw_c  = 1'b0;
		step_c = 2'sd0;
		cost_c = 2'd1;
		skip_c = 1'b0;
		pass   = 1'b1;
		a_zero = (a_q == 16'h0000);
		cond   = op_q inside {[w16alu_pkg::OP_IFB:w16alu_pkg::OP_IFU]};
		if (skip_q) begin
			// Skipped: conditionals chain the skip, others end it
			cost_c = cond ? 2'd1 : 2'd0;
			skip_c = cond;
		end else begin
			unique case (op_q)
				w16alu_pkg::OP_SET: begin
					res_c = a_q; wr_c = 1'b1;
				end
				w16alu_pkg::OP_ADD: begin
					res_c = add_s[15:0]; wr_c = 1'b1;
					exo_c = {15'h0, add_s[16]}; exw_c = 1'b1; cost_c = 2'd2;
				end
				w16alu_pkg::OP_SUB: begin
					res_c = sub_d; wr_c = 1'b1;
					exo_c = (b_q < a_q) ? 16'hffff : 16'h0000; exw_c = 1'b1; cost_c = 2'd2;
				end
				w16alu_pkg::OP_MUL, w16alu_pkg::OP_MLI: begin
					res_c = mul_p[15:0]; wr_c = 1'b1;
					exo_c = mul_p[31:16]; exw_c = 1'b1; cost_c = 2'd2;
				end
				w16alu_pkg::OP_DIV, w16alu_pkg::OP_DVI: begin
					res_c = a_zero ? 16'h0000 : q_hi;
					exo_c = a_zero ? 16'h0000 : q_lo;
					wr_c = 1'b1; exw_c = 1'b1; cost_c = 2'd3;
				end
				w16alu_pkg::OP_MOD, w16alu_pkg::OP_MDI: begin
					res_c = a_zero ? 16'h0000 : m_s;
					wr_c = 1'b1; cost_c = 2'd3;
				end
				w16alu_pkg::OP_AND: begin
					res_c = b_q & a_q; wr_c = 1'b1;
				end
				w16alu_pkg::OP_BOR: begin
					res_c = b_q | a_q; wr_c = 1'b1;
				end
				w16alu_pkg::OP_XOR: begin
					res_c = b_q ^ a_q; wr_c = 1'b1;
				end
				w16alu_pkg::OP_SHR: begin
					res_c = long_sh ? 16'h0000 : shr_w[31:16];
					exo_c = long_sh ? 16'h0000 : shr_w[15:0];
					wr_c = 1'b1; exw_c = 1'b1;
				end
				w16alu_pkg::OP_ASR: begin
					res_c = asr_r[15:0]; exo_c = asr_e[15:0];
					wr_c = 1'b1; exw_c = 1'b1;
				end
				w16alu_pkg::OP_SHL: begin
					res_c = long_sh ? 16'h0000 : shl_w[15:0];
					exo_c = long_sh ? 16'h0000 : shl_w[31:16];
					wr_c = 1'b1; exw_c = 1'b1;
				end
				w16alu_pkg::OP_IFB: pass = (b_q & a_q) != 16'h0000;
				w16alu_pkg::OP_IFC: pass = (b_q & a_q) == 16'h0000;
				w16alu_pkg::OP_IFE: pass = (b_q == a_q);
				w16alu_pkg::OP_IFN: pass = (b_q != a_q);
				w16alu_pkg::OP_IFG: pass = (b_q > a_q);
				w16alu_pkg::OP_IFA: pass = ($signed(b_q) > $signed(a_q));
				w16alu_pkg::OP_IFL: pass = (b_q < a_q);
				w16alu_pkg::OP_IFU: pass = ($signed(b_q) < $signed(a_q));
				w16alu_pkg::OP_ADX: begin
					res_c = adx_s[15:0]; wr_c = 1'b1;
					exo_c = {15'h0, |adx_s[17:16]}; exw_c = 1'b1; cost_c = 2'd3;
				end
				w16alu_pkg::OP_SBX: begin
					res_c = sbx_v[15:0]; wr_c = 1'b1;
					// Borrow gives all ones, carry out gives one
					if (sbx_v[17]) begin
						exo_c = 16'hffff;
					end else if (sbx_v[16]) begin
						exo_c = 16'h0001;
					end else begin
						exo_c = 16'h0000;
					end
					exw_c = 1'b1; cost_c = 2'd3;
				end
				w16alu_pkg::OP_STI: begin
					res_c = a_q; wr_c = 1'b1; step_c = 2'sd1; cost_c = 2'd2;
				end
				w16alu_pkg::OP_STD: begin
					res_c = a_q; wr_c = 1'b1; step_c = -2'sd1; cost_c = 2'd2;
				end
				default: cost_c = 2'd1;
			endcase
			// A failed test costs one more and skips the next instruction
			if (cond) begin
				skip_c = !pass;
				cost_c = 2'd2 + {1'b0, !pass};
			end
		end
	end

	// Skip flag is committed with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (load_out) begin
			skip_q <= skip_c;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q  <= res_c;
			exo_q  <= exo_c;
			wr_q   <= wr_c;
			exw_q  <= exw_c;
			skn_q  <= skip_c;
			step_q <= step_c;
			cost_q <= cost_c;
		end
	end

	assign result_word    = res_q;
	assign result_write   = wr_q;
	assign overflow_out   = exo_q;
	assign overflow_write = exw_q;
	assign skip_next      = skn_q;
	assign index_step     = step_q;
	assign cycle_cost     = cost_q;

	// An accepted beat keeps the input stalled in the next cycle
	a_accept_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a beat");

	// A pending result beat blocks new input
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// A skip decision never comes with a write
	a_skip_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && skip_next |-> !result_write && !overflow_write)
		else $error("write with skip set");

	// Index steps only come with a destination write
	a_step_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_step != 2'sd0 |-> result_write)
		else $error("index step without write");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench for word16_cpu_alu_execute: a directed table of instruction beats, then four
// random phases with different idling, every result checked against a fixed want or an in-bench model.
// Depends on w16alu_pkg and the execute unit top level.
module tb;

	// No beat moving for this many cycles means the unit is hung. The slowest legal gap
	// is a divide plus a long run of receiver stalls at 75 percent.
	localparam int WDOG_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 60;
	localparam int RAND_ITEMS  = 900;
	localparam int RST_CYCLES  = 11;

	// I/J step codes
	localparam logic [1:0] STEP_NONE = 2'b00;
	localparam logic [1:0] STEP_UP   = 2'b01;
	localparam logic [1:0] STEP_DOWN = 2'b11;

	// Opcodes with no meaning in the basic set
	localparam w16alu_pkg::opcode_t OP_RSVD_00 = 5'h00;
	localparam w16alu_pkg::opcode_t OP_RSVD_1C = 5'h1c;

	typedef struct packed {
		logic [15:0] res;
		logic        wr;
		logic [15:0] exo;
		logic        exw;
		logic        skip;
		logic [1:0]  step;
		logic [1:0]  cost;
	} alu_beat_t;

	typedef struct packed {
		w16alu_pkg::opcode_t op;
		logic [15:0]         b;
		logic [15:0]         a;
		logic [15:0]         ex;
		logic                fixed;
		alu_beat_t           want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [4:0]        opcode = '0;
	logic [15:0]       dest_value = '0;
	logic [15:0]       source_value = '0;
	logic [15:0]       overflow_in = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [15:0]       result_word;
	logic              result_write;
	logic [15:0]       overflow_out;
	logic              overflow_write;
	logic              skip_next;
	logic signed [1:0] index_step;
	logic [1:0]        cycle_cost;

	word16_cpu_alu_execute u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.dest_value     (dest_value),
		.source_value   (source_value),
		.overflow_in    (overflow_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_word    (result_word),
		.result_write   (result_write),
		.overflow_out   (overflow_out),
		.overflow_write (overflow_write),
		.skip_next      (skip_next),
		.index_step     (index_step),
		.cycle_cost     (cycle_cost)
	);

	w16alu_pkg::opcode_t valid_ops [27] = '{
		w16alu_pkg::OP_SET, w16alu_pkg::OP_ADD, w16alu_pkg::OP_SUB, w16alu_pkg::OP_MUL,
		w16alu_pkg::OP_MLI, w16alu_pkg::OP_DIV, w16alu_pkg::OP_DVI, w16alu_pkg::OP_MOD,
		w16alu_pkg::OP_MDI, w16alu_pkg::OP_AND, w16alu_pkg::OP_BOR, w16alu_pkg::OP_XOR,
		w16alu_pkg::OP_SHR, w16alu_pkg::OP_ASR, w16alu_pkg::OP_SHL, w16alu_pkg::OP_IFB,
		w16alu_pkg::OP_IFC, w16alu_pkg::OP_IFE, w16alu_pkg::OP_IFN, w16alu_pkg::OP_IFG,
		w16alu_pkg::OP_IFA, w16alu_pkg::OP_IFL, w16alu_pkg::OP_IFU, w16alu_pkg::OP_ADX,
		w16alu_pkg::OP_SBX, w16alu_pkg::OP_STI, w16alu_pkg::OP_STD};
	w16alu_pkg::opcode_t cond_ops [8] = '{
		w16alu_pkg::OP_IFB, w16alu_pkg::OP_IFC, w16alu_pkg::OP_IFE, w16alu_pkg::OP_IFN,
		w16alu_pkg::OP_IFG, w16alu_pkg::OP_IFA, w16alu_pkg::OP_IFL, w16alu_pkg::OP_IFU};

	dir_row_t  dir_tab [$];
	alu_beat_t pending_results [$];
	alu_beat_t got_beat;
	alu_beat_t want_beat;
	logic      skip_pend = 1'b0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        err_cnt = 0;
	int        checked_cnt = 0;
	int        skip_cnt = 0;
	int        rand_sent = 0;
	int        idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Expected result of one executed beat; updates the kept skip flag
	function automatic alu_beat_t exec_predict(w16alu_pkg::opcode_t op, logic [15:0] b,
		logic [15:0] a, logic [15:0] ex);
		alu_beat_t          r;
		logic [16:0]        sum17;
		logic [31:0]        wide;
		logic [63:0]        w64;
		logic signed [31:0] sb;
		logic signed [31:0] sa;
		logic signed [31:0] sv;
		longint             sq;
		logic [4:0]         sh;
		logic               cond;
		logic               pass;
		r.res  = b;
		r.wr   = 1'b0;
		r.exo  = ex;
		r.exw  = 1'b0;
		r.skip = 1'b0;
		r.step = STEP_NONE;
		r.cost = 2'd1;
		sb     = $signed({{16{b[15]}}, b});
		sa     = $signed({{16{a[15]}}, a});
		cond   = (op >= w16alu_pkg::OP_IFB) && (op <= w16alu_pkg::OP_IFU);
		pass   = 1'b1;
		if (skip_pend) begin
			// skipped beat: conditionals keep the chain going
			r.cost    = cond ? 2'd1 : 2'd0;
			skip_pend = cond;
		end else begin
			skip_pend = 1'b0;
			case (op)
				w16alu_pkg::OP_SET: begin
					r.res = a;
					r.wr  = 1'b1;
				end
				w16alu_pkg::OP_ADD: begin
					sum17 = {1'b0, b} + {1'b0, a};
					r.res = sum17[15:0];
					r.exo = {15'd0, sum17[16]};
					r.wr  = 1'b1;
					r.exw = 1'b1;
					r.cost = 2'd2;
				end
				w16alu_pkg::OP_SUB: begin
					r.res = b - a;
					r.exo = (b < a) ? 16'hffff : 16'h0000;
					r.wr  = 1'b1;
					r.exw = 1'b1;
					r.cost = 2'd2;
				end
				w16alu_pkg::OP_MUL, w16alu_pkg::OP_MLI: begin
					wide  = (op == w16alu_pkg::OP_MUL) ? {16'd0, b} * {16'd0, a} : sb * sa;
					r.res = wide[15:0];
					r.exo = wide[31:16];
					r.wr  = 1'b1;
					r.exw = 1'b1;
					r.cost = 2'd2;
				end
				w16alu_pkg::OP_DIV: begin
					if (a != 16'd0) begin
						r.res = b / a;
						wide  = {b, 16'd0} / {16'd0, a};
						r.exo = wide[15:0];
					end else begin
						r.res = 16'd0;
						r.exo = 16'd0;
					end
					r.wr  = 1'b1;
					r.exw = 1'b1;
					r.cost = 2'd3;
				end
				w16alu_pkg::OP_DVI: begin
					if (a != 16'd0) begin
						sq    = longint'(sb) / longint'(sa);
						r.res = sq[15:0];
						sq    = (longint'(sb) * 65536) / longint'(sa);
						r.exo = sq[15:0];
					end else begin
						r.res = 16'd0;
						r.exo = 16'd0;
					end
					r.wr  = 1'b1;
					r.exw = 1'b1;
					r.cost = 2'd3;
				end
				w16alu_pkg::OP_MOD: begin
					r.res = (a != 16'd0) ? b % a : 16'd0;
					r.wr  = 1'b1;
					r.cost = 2'd3;
				end
				w16alu_pkg::OP_MDI: begin
					sv    = (a != 16'd0) ? sb % sa : 32'sd0;
					r.res = sv[15:0];
					r.wr  = 1'b1;
					r.cost = 2'd3;
				end
				w16alu_pkg::OP_AND: begin
					r.res = b & a;
					r.wr  = 1'b1;
				end
				w16alu_pkg::OP_BOR: begin
					r.res = b | a;
					r.wr  = 1'b1;
				end
				w16alu_pkg::OP_XOR: begin
					r.res = b ^ a;
					r.wr  = 1'b1;
				end
				w16alu_pkg::OP_SHR: begin
					if (a >= 16'd32) begin
						r.res = 16'd0;
						r.exo = 16'd0;
					end else begin
						r.res = b >> a[4:0];
						wide  = {b, 16'd0} >> a[4:0];
						r.exo = wide[15:0];
					end
					r.wr  = 1'b1;
					r.exw = 1'b1;
				end
				w16alu_pkg::OP_ASR: begin
					// long shifts saturate at 31, which is full sign fill
					sh    = (a >= 16'd31) ? 5'd31 : a[4:0];
					sv    = sb >>> sh;
					r.res = sv[15:0];
					sv    = $signed({b, 16'd0}) >>> sh;
					r.exo = sv[15:0];
					r.wr  = 1'b1;
					r.exw = 1'b1;
				end
				w16alu_pkg::OP_SHL: begin
					if (a >= 16'd32) begin
						r.res = 16'd0;
						r.exo = 16'd0;
					end else begin
						w64   = {48'd0, b} << a[4:0];
						r.res = w64[15:0];
						r.exo = w64[31:16];
					end
					r.wr  = 1'b1;
					r.exw = 1'b1;
				end
				w16alu_pkg::OP_IFB: pass = (b & a) != 16'd0;
				w16alu_pkg::OP_IFC: pass = (b & a) == 16'd0;
				w16alu_pkg::OP_IFE: pass = (b == a);
				w16alu_pkg::OP_IFN: pass = (b != a);
				w16alu_pkg::OP_IFG: pass = (b > a);
				w16alu_pkg::OP_IFA: pass = (sb > sa);
				w16alu_pkg::OP_IFL: pass = (b < a);
				w16alu_pkg::OP_IFU: pass = (sb < sa);
				w16alu_pkg::OP_ADX: begin
					wide  = {16'd0, b} + {16'd0, a} + {16'd0, ex};
					r.res = wide[15:0];
					r.exo = (wide[31:16] != 16'd0) ? 16'd1 : 16'd0;
					r.wr  = 1'b1;
					r.exw = 1'b1;
					r.cost = 2'd3;
				end
				w16alu_pkg::OP_SBX: begin
					sv    = $signed({16'd0, b}) - $signed({16'd0, a}) + $signed({16'd0, ex});
					r.res = sv[15:0];
					if (sv < 0)
						r.exo = 16'hffff;
					else
						r.exo = (sv > 32'sh0000ffff) ? 16'd1 : 16'd0;
					r.wr  = 1'b1;
					r.exw = 1'b1;
					r.cost = 2'd3;
				end
				w16alu_pkg::OP_STI, w16alu_pkg::OP_STD: begin
					r.res  = a;
					r.wr   = 1'b1;
					r.step = (op == w16alu_pkg::OP_STI) ? STEP_UP : STEP_DOWN;
					r.cost = 2'd2;
				end
				default: r.cost = 2'd1;
			endcase
			// a failed test arms the skip and costs one more
			if (cond) begin
				skip_pend = !pass;
				r.cost    = pass ? 2'd2 : 2'd3;
			end
		end
		r.skip = skip_pend;
		return r;
	endfunction

	function automatic alu_beat_t beat(logic [15:0] res, logic wr, logic [15:0] exo,
		logic exw, logic skip, logic [1:0] step, logic [1:0] cost);
		alu_beat_t r;
		r = {res, wr, exo, exw, skip, step, cost};
		return r;
	endfunction

	task automatic tab_chk(w16alu_pkg::opcode_t op, logic [15:0] b, logic [15:0] a,
		logic [15:0] ex);
		dir_row_t row;
		row    = '0;
		row.op = op;
		row.b  = b;
		row.a  = a;
		row.ex = ex;
		dir_tab.push_back(row);
	endtask

	task automatic tab_fix(w16alu_pkg::opcode_t op, logic [15:0] b, logic [15:0] a,
		logic [15:0] ex, alu_beat_t want);
		dir_row_t row;
		row.op    = op;
		row.b     = b;
		row.a     = a;
		row.ex    = ex;
		row.fixed = 1'b1;
		row.want  = want;
		dir_tab.push_back(row);
	endtask

	// Present one instruction beat and hold it until taken
	task automatic send_beat(w16alu_pkg::opcode_t op, logic [15:0] b, logic [15:0] a,
		logic [15:0] ex, logic fixed, alu_beat_t want);
		alu_beat_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		dest_value   <= b;
		source_value <= a;
		overflow_in  <= ex;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = exec_predict(op, b, a, ex);
		pending_results.push_back(fixed ? want : pred);
	endtask

	// Hold off the sender until every expected result is out
	task automatic wait_drain();
		while (pending_results.size() != 0) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000;
			3: return 16'h7fff;
			4: return 16'($urandom_range(40));
			default: return 16'($urandom);
		endcase
	endfunction

	// Receiver stall pattern
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_beat = {result_word, result_write, overflow_out, overflow_write, skip_next,
				index_step, cycle_cost};
			if (pending_results.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("[%0t] result beat with nothing expected: res=%h", $realtime,
						result_word);
			end else begin
				want_beat = pending_results.pop_front();
				checked_cnt++;
				if (got_beat.skip === 1'b1)
					skip_cnt++;
				if (got_beat.res !== want_beat.res || got_beat.wr !== want_beat.wr ||
					got_beat.exo !== want_beat.exo || got_beat.exw !== want_beat.exw ||
					got_beat.skip !== want_beat.skip || got_beat.step !== want_beat.step ||
					got_beat.cost !== want_beat.cost) begin
					err_cnt++;
					if (err_cnt <= 10) begin
						$display({"[%0t] mismatch want res=%h wr=%b ex=%h exw=%b",
							" skip=%b step=%b cost=%0d"},
							$realtime, want_beat.res, want_beat.wr, want_beat.exo,
							want_beat.exw, want_beat.skip, want_beat.step, want_beat.cost);
						$display({"          got  res=%h wr=%b ex=%h exw=%b",
							" skip=%b step=%b cost=%0d"},
							got_beat.res, got_beat.wr, got_beat.exo, got_beat.exw,
							got_beat.skip, got_beat.step, got_beat.cost);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", WDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		w16alu_pkg::opcode_t rop;
		logic [15:0]         rb;
		logic [15:0]         ra;
		logic [15:0]         rex;
		int                  k;

		// directed rows with obvious answers
		tab_fix(w16alu_pkg::OP_SET, 16'h1234, 16'hffff, 16'h5555,
			beat(16'hffff, 1'b1, 16'h5555, 1'b0, 1'b0, STEP_NONE, 2'd1));
		tab_fix(w16alu_pkg::OP_ADD, 16'hffff, 16'hffff, 16'h0000,
			beat(16'hfffe, 1'b1, 16'h0001, 1'b1, 1'b0, STEP_NONE, 2'd2));
		tab_fix(w16alu_pkg::OP_SUB, 16'h0000, 16'h0001, 16'h0000,
			beat(16'hffff, 1'b1, 16'hffff, 1'b1, 1'b0, STEP_NONE, 2'd2));
		tab_fix(w16alu_pkg::OP_MUL, 16'hffff, 16'hffff, 16'h0000,
			beat(16'h0001, 1'b1, 16'hfffe, 1'b1, 1'b0, STEP_NONE, 2'd2));
		tab_fix(w16alu_pkg::OP_MLI, 16'hffff, 16'hffff, 16'h0000,
			beat(16'h0001, 1'b1, 16'h0000, 1'b1, 1'b0, STEP_NONE, 2'd2));
		// divide by zero
		tab_fix(w16alu_pkg::OP_DIV, 16'hffff, 16'h0000, 16'h1234,
			beat(16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0, STEP_NONE, 2'd3));
		// signed divide overflow
		tab_fix(w16alu_pkg::OP_DVI, 16'h8000, 16'hffff, 16'h0000,
			beat(16'h8000, 1'b1, 16'h0000, 1'b1, 1'b0, STEP_NONE, 2'd3));
		tab_fix(w16alu_pkg::OP_MOD, 16'hffff, 16'h0000, 16'h1234,
			beat(16'h0000, 1'b1, 16'h1234, 1'b0, 1'b0, STEP_NONE, 2'd3));
		tab_fix(w16alu_pkg::OP_MDI, 16'h8000, 16'h0000, 16'h4321,
			beat(16'h0000, 1'b1, 16'h4321, 1'b0, 1'b0, STEP_NONE, 2'd3));
		// long shifts
		tab_fix(w16alu_pkg::OP_SHR, 16'hffff, 16'h0020, 16'h7777,
			beat(16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0, STEP_NONE, 2'd1));
		tab_fix(w16alu_pkg::OP_ASR, 16'h8000, 16'hffff, 16'h0000,
			beat(16'hffff, 1'b1, 16'hffff, 1'b1, 1'b0, STEP_NONE, 2'd1));
		tab_fix(w16alu_pkg::OP_SHL, 16'hffff, 16'h0020, 16'h0000,
			beat(16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0, STEP_NONE, 2'd1));
		tab_fix(w16alu_pkg::OP_ADX, 16'hffff, 16'hffff, 16'hffff,
			beat(16'hfffd, 1'b1, 16'h0001, 1'b1, 1'b0, STEP_NONE, 2'd3));
		// subtract with carry underflow
		tab_fix(w16alu_pkg::OP_SBX, 16'h0000, 16'hffff, 16'h0000,
			beat(16'h0001, 1'b1, 16'hffff, 1'b1, 1'b0, STEP_NONE, 2'd3));
		tab_fix(w16alu_pkg::OP_STI, 16'h0000, 16'habcd, 16'h0000,
			beat(16'habcd, 1'b1, 16'h0000, 1'b0, 1'b0, STEP_UP, 2'd2));
		tab_fix(w16alu_pkg::OP_STD, 16'h0000, 16'hffff, 16'h0000,
			beat(16'hffff, 1'b1, 16'h0000, 1'b0, 1'b0, STEP_DOWN, 2'd2));
		tab_fix(OP_RSVD_00, 16'hbeef, 16'h0001, 16'h0002,
			beat(16'hbeef, 1'b0, 16'h0002, 1'b0, 1'b0, STEP_NONE, 2'd1));
		// failed test, skipped conditional keeps the chain, skipped ADD ends it
		tab_fix(w16alu_pkg::OP_IFE, 16'h0001, 16'h0002, 16'h0000,
			beat(16'h0001, 1'b0, 16'h0000, 1'b0, 1'b1, STEP_NONE, 2'd3));
		tab_fix(w16alu_pkg::OP_IFU, 16'h8000, 16'h0001, 16'h0000,
			beat(16'h8000, 1'b0, 16'h0000, 1'b0, 1'b1, STEP_NONE, 2'd1));
		tab_fix(w16alu_pkg::OP_ADD, 16'h0005, 16'h0006, 16'h0007,
			beat(16'h0005, 1'b0, 16'h0007, 1'b0, 1'b0, STEP_NONE, 2'd0));
		// the rest of the opcodes, checked by the model
		tab_chk(w16alu_pkg::OP_DIV, 16'h1234, 16'h0007, 16'h0000);
		tab_chk(w16alu_pkg::OP_DVI, 16'hff00, 16'h0003, 16'h0000);
		tab_chk(w16alu_pkg::OP_MOD, 16'hffff, 16'h0010, 16'h0000);
		tab_chk(w16alu_pkg::OP_MDI, 16'hfff9, 16'h0004, 16'h0000);
		tab_chk(w16alu_pkg::OP_AND, 16'ha5a5, 16'h0ff0, 16'h0000);
		tab_chk(w16alu_pkg::OP_BOR, 16'ha5a5, 16'h0ff0, 16'h0000);
		tab_chk(w16alu_pkg::OP_XOR, 16'ha5a5, 16'h0ff0, 16'h0000);
		tab_chk(w16alu_pkg::OP_IFB, 16'h00f0, 16'h0010, 16'h0000);
		tab_chk(w16alu_pkg::OP_IFC, 16'h00f0, 16'h0f00, 16'h0000);
		tab_chk(w16alu_pkg::OP_IFG, 16'hffff, 16'h0000, 16'h0000);
		tab_chk(w16alu_pkg::OP_IFA, 16'h0001, 16'hffff, 16'h0000);
		tab_chk(w16alu_pkg::OP_IFL, 16'h0000, 16'hffff, 16'h0000);
		tab_chk(w16alu_pkg::OP_IFN, 16'h0001, 16'h0002, 16'h0000);
		tab_chk(w16alu_pkg::OP_SBX, 16'hffff, 16'h0000, 16'hffff);

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (dir_tab[i])
			send_beat(dir_tab[i].op, dir_tab[i].b, dir_tab[i].a, dir_tab[i].ex,
				dir_tab[i].fixed, dir_tab[i].want);
		wait_drain();

		// random phases: free run, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 75 : ((ph == 3) ? 13 : 0);
			recv_stall_pct = (ph == 2) ? 75 : ((ph == 3) ? 13 : 0);
			for (int n = 0; n < RAND_ITEMS / 4; n++) begin
				k = $urandom_range(99);
				if (k < 5)
					rop = w16alu_pkg::opcode_t'($urandom_range(31));
				else if (k < 35)
					rop = cond_ops[$urandom_range(7)];
				else
					rop = valid_ops[$urandom_range(26)];
				rb  = rand_word();
				ra  = rand_word();
				rex = rand_word();
				if ((rop == w16alu_pkg::OP_SHR || rop == w16alu_pkg::OP_ASR ||
					rop == w16alu_pkg::OP_SHL) && $urandom_range(1))
					ra = 16'($urandom_range(40));
				if (rop >= w16alu_pkg::OP_IFB && rop <= w16alu_pkg::OP_IFU &&
					$urandom_range(3) == 0)
					ra = rb;
				if (rop == OP_RSVD_1C && $urandom_range(1))
					rop = OP_RSVD_00;
				send_beat(rop, rb, ra, rex, 1'b0, '0);
				rand_sent++;
			end
			wait_drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		err_cnt += pending_results.size();

		$display("Covered %0d directed and %0d random instruction beats over four idle mixes;",
			dir_tab.size(), rand_sent);
		$display("%0d results checked, %0d of them arming a skip.", checked_cnt, skip_cnt);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/w16alu_pkg.sv
rtl/core/word16_cpu_alu_execute.sv
test/tb.sv
